// File: src/nibble_bitmap_row_scaler_core_defines.svh
// assertion macros shared by the row scaler modules
`ifndef NIBBLE_BITMAP_ROW_SCALER_CORE_DEFINES_SVH
`define NIBBLE_BITMAP_ROW_SCALER_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define NBRS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NBRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/nbrs_pkg.sv
// shared types and constants for the nibble row scaler
`timescale 1ns / 1ps

package nbrs_pkg;

   localparam int MAX_ROW_BYTES_DEF = 256;

   // request actions
   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_READ  = 1'b1;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_LENGTH = 1'b1;

   // divider: the nibble offset is below 512, so nine quotient bits
   localparam int DIV_STEPS = 9;
   localparam int DIV_CNT_W = 4;

   typedef struct packed {
      logic write_byte;   // store request byte, advance write position
      logic begin_read;   // latch the scaled row index
      logic low_nibble;   // which nibble of the output byte is being computed
      logic mul;          // product of nibble index and source length
      logic div_init;     // load divider from product
      logic div_step;     // one restoring division step
      logic mem_read;     // read the source byte that holds the quotient nibble
      logic take_nibble;  // pick the nibble from the read byte
      logic finish;       // present result, update read position
   } nbrs_cmd_type;

endpackage

// File: src/nibble_bitmap_row_scaler_core.sv
// top level of the nearest-neighbor 4-bit pixel row scaler
`timescale 1ns / 1ps

// Requests are taken when start is high and busy is low. A write request
// (action 0) stores one packed source byte in the same cycle and never raises
// busy, so writes go at one per clock. A read request (action 1) holds busy
// while each of the two output nibbles takes a multiply, a divider load, a
// nine-step restoring divide by target_length, one row memory read and a
// nibble select. The scaled byte and row_done appear in the first cycle with
// busy low again, marked by rsp_strobe for exactly one cycle; the receiver
// cannot stall, so it must take the result then. A new request may be issued
// in that same cycle. The row memory has no reset; write a full source row
// before reading. Length registers are to be written only while the block
// is idle; the user is bound by this, the block itself does not enforce it.
module nibble_bitmap_row_scaler_core #(
   parameter int MAX_ROW_BYTES = nbrs_pkg::MAX_ROW_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_action,
   input  logic [7:0]                       req_source_byte,
   output logic                             rsp_strobe,
   output logic [7:0]                       rsp_scaled_byte,
   output logic                             rsp_row_done,
   input  logic                             csr_write_enable,
   input  logic [nbrs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_write_data
);

   nbrs_pkg::nbrs_cmd_type cmd;

   nbrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .busy       (busy),
      .cmd        (cmd)
   );

   nbrs_datapath #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_source_byte  (req_source_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_scaled_byte  (rsp_scaled_byte),
      .rsp_row_done     (rsp_row_done)
   );

endmodule

// File: src/nbrs_ctrl.sv
// controller state machine sequencing writes and scaled reads
`timescale 1ns / 1ps
`include "nibble_bitmap_row_scaler_core_defines.svh"

module nbrs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_action,
   output logic                 busy,
   output nbrs_pkg::nbrs_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_MUL      = 3'd1;
   localparam logic [2:0] ST_DIV_INIT = 3'd2;
   localparam logic [2:0] ST_DIV      = 3'd3;
   localparam logic [2:0] ST_MEM      = 3'd4;
   localparam logic [2:0] ST_SEL      = 3'd5;

   localparam logic [nbrs_pkg::DIV_CNT_W-1:0] DIV_LAST =
      nbrs_pkg::DIV_CNT_W'(nbrs_pkg::DIV_STEPS - 1);

   logic [2:0]                     state_ff, state_in;
   logic [nbrs_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           nib_ff, nib_in;
   logic                           accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      nib_in   = nib_ff;
      cmd      = '0;
      cmd.low_nibble = nib_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == nbrs_pkg::ACTION_WRITE) begin
                  cmd.write_byte = 1'b1;
               end else begin
                  cmd.begin_read = 1'b1;
                  nib_in   = 1'b0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_MEM;
            end
         end
         ST_MEM: begin
            cmd.mem_read = 1'b1;
            state_in = ST_SEL;
         end
         ST_SEL: begin
            cmd.take_nibble = 1'b1;
            if (nib_ff) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end else begin
               nib_in   = 1'b1;
               state_in = ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         nib_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         nib_ff   <= nib_in;
      end
   end

   // a write request never leaves the idle state
   `NBRS_ASSERT_NEXT(a_write_stays_idle, accept && req_action == nbrs_pkg::ACTION_WRITE, !busy, "write request made the controller busy")
   // divider runs exactly its step count before the memory read
   `NBRS_ASSERT_NEXT(a_div_length, state_ff == ST_DIV && cnt_ff == DIV_LAST, state_ff == ST_MEM, "divider did not stop after last step")
   // the high nibble is always computed before the result is presented
   `NBRS_ASSERT_NOW(a_finish_low, cmd.finish, nib_ff && !accept, "result finished on the high nibble")

endmodule

// File: src/nbrs_datapath.sv
// datapath: length registers, source row memory, multiplier, serial divider
`timescale 1ns / 1ps
`include "nibble_bitmap_row_scaler_core_defines.svh"

module nbrs_datapath #(
   parameter int MAX_ROW_BYTES = nbrs_pkg::MAX_ROW_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  nbrs_pkg::nbrs_cmd_type              cmd,
   input  logic [7:0]                          req_source_byte,
   input  logic                                csr_write_enable,
   input  logic [nbrs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [7:0]                          csr_write_data,
   output logic                                rsp_strobe,
   output logic [7:0]                          rsp_scaled_byte,
   output logic                                rsp_row_done
);

   localparam int AW = $clog2(MAX_ROW_BYTES);

   logic [7:0]  src_len_ff, src_len_in;
   logic [7:0]  tgt_len_ff, tgt_len_in;
   logic [7:0]  wp_ff, wp_in;
   logic [7:0]  rp_ff, rp_in;
   logic        strobe_ff, strobe_in;

   logic [7:0]  row_ff;
   logic [16:0] prod_ff;
   logic [7:0]  rem_ff;
   logic [8:0]  quo_ff;
   logic [7:0]  rdata_ff;
   logic [3:0]  hi_ff;
   logic [7:0]  scaled_ff;
   logic        done_ff;

   logic [7:0]  mem [MAX_ROW_BYTES];

   logic [7:0]  src_eff, tgt_eff;
   logic [8:0]  idx;
   logic [16:0] mul_res;
   logic [8:0]  trial, diff;
   logic        ge;
   logic [3:0]  nibble;
   logic        last;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [AW-1:0] addr_tab [256];

   // write and read address folding onto the row memory depth
   for (genvar g = 0; g < 256; g++) begin : g_addr_tab
      assign addr_tab[g] = AW'(g % MAX_ROW_BYTES);
   end

   assign wr_addr = addr_tab[wp_ff];
   assign rd_addr = addr_tab[quo_ff[8:1]];

   assign src_eff = (src_len_ff == 8'd0) ? 8'd1 : src_len_ff;
   assign tgt_eff = (tgt_len_ff == 8'd0) ? 8'd1 : tgt_len_ff;

   // nibble index times source length
   assign idx     = {row_ff, cmd.low_nibble};
   assign mul_res = {8'd0, idx} * {9'd0, src_eff};

   // restoring division by the target length, quotient shifts into quo_ff
   assign trial = {rem_ff, quo_ff[8]};
   assign ge    = (trial >= {1'b0, tgt_eff});
   assign diff  = trial - {1'b0, tgt_eff};

   assign nibble = quo_ff[0] ? rdata_ff[3:0] : rdata_ff[7:4];
   assign last   = (({1'b0, row_ff} + 9'd1) >= {1'b0, tgt_eff});

   always_comb begin
      src_len_in = src_len_ff;
      tgt_len_in = tgt_len_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      strobe_in  = cmd.finish;
      if (csr_write_enable) begin
         case (csr_index)
            nbrs_pkg::REG_SOURCE_LENGTH: src_len_in = csr_write_data;
            nbrs_pkg::REG_TARGET_LENGTH: tgt_len_in = csr_write_data;
            default: begin
            end
         endcase
      end
      if (cmd.write_byte) begin
         // finished load restarts both positions
         if (({1'b0, wp_ff} + 9'd1) >= {1'b0, src_eff}) begin
            wp_in = '0;
            rp_in = '0;
         end else begin
            wp_in = wp_ff + 8'd1;
         end
      end
      if (cmd.finish) begin
         rp_in = last ? 8'd0 : (row_ff + 8'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_len_ff <= 8'd1;
         tgt_len_ff <= 8'd1;
         wp_ff      <= '0;
         rp_ff      <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         src_len_ff <= src_len_in;
         tgt_len_ff <= tgt_len_in;
         wp_ff      <= wp_in;
         rp_ff      <= rp_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.begin_read) begin
         // a lowered target length restarts the row
         row_ff <= (rp_ff >= tgt_eff) ? 8'd0 : rp_ff;
      end
      if (cmd.mul) begin
         prod_ff <= mul_res;
      end
      if (cmd.div_init) begin
         rem_ff <= prod_ff[16:9];
         quo_ff <= prod_ff[8:0];
      end else if (cmd.div_step) begin
         rem_ff <= ge ? diff[7:0] : trial[7:0];
         quo_ff <= {quo_ff[7:0], ge};
      end
      if (cmd.take_nibble && !cmd.low_nibble) begin
         hi_ff <= nibble;
      end
      if (cmd.finish) begin
         scaled_ff <= {hi_ff, nibble};
         done_ff   <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_byte) begin
         mem[wr_addr] <= req_source_byte;
      end
      if (cmd.mem_read) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_scaled_byte = scaled_ff;
   assign rsp_row_done    = done_ff;

   // each result follows exactly one finish command
   `NBRS_ASSERT_NEXT(a_strobe_follows_finish, cmd.finish, rsp_strobe, "finish did not raise the result strobe")
   `NBRS_ASSERT_NEXT(a_no_double_strobe, rsp_strobe, !rsp_strobe, "result strobe held for two cycles")
   // a row end always rewinds the read position
   `NBRS_ASSERT_NEXT(a_row_done_rewinds, cmd.finish && last, rp_ff == 8'd0 && rsp_row_done, "row end did not rewind read position")

endmodule
